[hdl/mtpm_pkg.sv]
// Shared types, sizes and codes for the multi-track pattern matcher.
package mtpm_pkg;

	localparam int TRACKS   = 4;
	localparam int ALPHABET = 16;
	localparam int NODES    = 64;
	localparam int MAX_LEN  = 16;

	localparam int NODE_W   = 6;
	localparam int SYM_W    = 4;
	localparam int CHILD_AW = NODE_W + SYM_W;
	localparam int CHILD_DW = NODE_W + 1;
	localparam int DEPTH_W  = 5;
	localparam int WEIGHT_W = 3;
	localparam int ENTRY_W  = DEPTH_W + WEIGHT_W + NODE_W;
	localparam int COLS_W   = 16;
	localparam int TRK_W    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int STEP_W   = $clog2(TRACKS + 1);
	localparam int ATT_W    = $clog2(MAX_LEN + 1);
	localparam int CNT_W    = $clog2(TRACKS + 1);

	// request codes
	localparam logic [1:0] REQ_CHILD = 2'd0;
	localparam logic [1:0] REQ_NODE  = 2'd1;
	localparam logic [1:0] REQ_TEXT  = 2'd2;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [NODE_W-1:0]   node_index;
		logic [SYM_W-1:0]    symbol;
		logic [NODE_W-1:0]   child_node;
		logic                child_valid;
		logic [DEPTH_W-1:0]  node_depth;
		logic [WEIGHT_W-1:0] node_weight;
		logic [NODE_W-1:0]   failure_node;
		logic [COLS_W-1:0]   column_symbols;
		logic                text_start;
	} req_item_t;

	typedef struct packed {
		logic        match_found;
		logic [31:0] match_position;
	} rsp_item_t;

	// symbol of one track in a column; tracks past the field read zero
	function automatic logic [SYM_W-1:0] track_sym(input logic [COLS_W-1:0] cols,
		input logic [TRK_W-1:0] trk);
		logic [SYM_W-1:0] s;
		s = '0;
		for (int b = 0; b < COLS_W / 4; b++) begin
			if (int'(trk) == b) begin
				s = SYM_W'(cols[4*b +: 4]);
			end
		end
		return s;
	endfunction

endpackage

[hdl/multi_track_pattern_matcher_top.sv]
// Top level of the multi-track pattern matcher: sequencer around two tables.
//
//  channel | direction | handshake          | item
//  req     | in        | req_valid/stall    | req_item_t (table write or text column)
//  rsp     | out       | rsp_valid/stall    | rsp_item_t, one per text column
//  cfg     | in        | cfg_valid/ready    | pattern_length
//
// A text column runs A attempts (1..MAX_LEN+1): a child pass, a weight pass
// and a decision each, with a failure-link pass between attempts; an attempt
// with a missing child skips the weight pass. Each table has a single read
// port, walked once per track.
// After reset a clearing pass writes all NODES*ALPHABET child entries, one a
// cycle, with req_stall high. A stalled result holds in the output register;
// the next column's result waits in the result state until that one is taken.
module multi_track_pattern_matcher_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  mtpm_pkg::req_item_t   req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output mtpm_pkg::rsp_item_t   rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [4:0]            cfg_data
);
	import mtpm_pkg::*;

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_CHILD  = 3'd2;
	localparam logic [2:0] ST_WEIGHT = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_FAIL   = 3'd5;
	localparam logic [2:0] ST_DEPTH  = 3'd6;
	localparam logic [2:0] ST_RES    = 3'd7;

	logic [2:0]            state_q;
	logic [CHILD_AW-1:0]   clr_q;
	logic [4:0]            plen_q;
	logic [NODE_W-1:0]     track_q [TRACKS];
	logic [NODE_W-1:0]     nxt_q [TRACKS];
	logic [WEIGHT_W-1:0]   wgt_q [TRACKS];
	logic [COLS_W-1:0]     col_q;
	logic [STEP_W-1:0]     step_q;
	logic [ATT_W-1:0]      attempt_q;
	logic                  fail_q;
	logic [31:0]           count_q;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;

	logic                  accept;
	logic [TRK_W-1:0]      iss_idx;
	logic [TRK_W-1:0]      cap_idx;
	logic                  issuing;
	logic                  capturing;
	logic                  ch_we;
	logic [CHILD_AW-1:0]   ch_waddr;
	logic [CHILD_DW-1:0]   ch_wdata;
	logic [CHILD_AW-1:0]   ch_raddr;
	logic [CHILD_DW-1:0]   ch_rdata;
	logic                  nd_we;
	logic [ENTRY_W-1:0]    nd_wdata;
	logic [NODE_W-1:0]     nd_raddr;
	logic [ENTRY_W-1:0]    nd_rdata;
	logic                  weights_ok;
	logic                  load_rsp;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign iss_idx   = TRK_W'(step_q);
	assign cap_idx   = TRK_W'(step_q - 1'b1);
	assign issuing   = (step_q < STEP_W'(TRACKS));
	assign capturing = (step_q != '0);
	assign load_rsp  = (state_q == ST_RES) && (!rsp_valid_q || !rsp_stall);

	// child table write: clearing pass or table-write item
	always_comb begin
		ch_we    = 1'b0;
		ch_waddr = {req.node_index, req.symbol};
		ch_wdata = req.child_valid ? {1'b1, req.child_node} : '0;
		if (state_q == ST_CLR) begin
			ch_we    = 1'b1;
			ch_waddr = clr_q;
			ch_wdata = '0;
		end else if (accept && req.req_type == REQ_CHILD) begin
			ch_we = 1'b1;
		end
	end

	assign ch_raddr = {track_q[iss_idx], track_sym(col_q, iss_idx)};
	assign nd_we    = accept && (req.req_type == REQ_NODE);
	assign nd_wdata = {req.node_depth, req.node_weight, req.failure_node};

	// node table read address by phase
	always_comb begin
		case (state_q)
			ST_WEIGHT: nd_raddr = nxt_q[iss_idx];
			ST_FAIL:   nd_raddr = track_q[iss_idx];
			default:   nd_raddr = track_q[0];
		endcase
	end

	// no next node reached by more tracks than its weight
	always_comb begin
		logic [CNT_W-1:0] cnt;
		weights_ok = 1'b1;
		for (int j = 0; j < TRACKS; j++) begin
			cnt = '0;
			for (int k = 0; k < TRACKS; k++) begin
				if (nxt_q[k] == nxt_q[j]) begin
					cnt = cnt + 1'b1;
				end
			end
			if (cnt > CNT_W'(wgt_q[j])) begin
				weights_ok = 1'b0;
			end
		end
	end

	mtpm_child_mem u_child (
		.clk   (clk),
		.we    (ch_we),
		.waddr (ch_waddr),
		.wdata (ch_wdata),
		.raddr (ch_raddr),
		.rdata (ch_rdata)
	);

	mtpm_node_mem u_node (
		.clk   (clk),
		.we    (nd_we),
		.waddr (req.node_index),
		.wdata (nd_wdata),
		.raddr (nd_raddr),
		.rdata (nd_rdata)
	);

	// sequencer and track state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			plen_q      <= 5'd1;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			step_q      <= '0;
			attempt_q   <= '0;
			fail_q      <= 1'b0;
			for (int j = 0; j < TRACKS; j++) begin
				track_q[j] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				plen_q <= cfg_data;
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CHILD_AW'(NODES*ALPHABET - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && req.req_type == REQ_TEXT) begin
						if (req.text_start) begin
							for (int j = 0; j < TRACKS; j++) begin
								track_q[j] <= '0;
							end
							count_q <= '0;
						end
						col_q     <= req.column_symbols;
						attempt_q <= '0;
						fail_q    <= 1'b0;
						step_q    <= '0;
						state_q   <= ST_CHILD;
					end
				end
				ST_CHILD: begin
					if (capturing) begin
						nxt_q[cap_idx] <= ch_rdata[NODE_W-1:0];
						if (!ch_rdata[CHILD_DW-1]) begin
							fail_q <= 1'b1;
						end
					end
					step_q <= issuing ? step_q + 1'b1 : '0;
					if (!issuing) begin
						state_q <= (fail_q || !ch_rdata[CHILD_DW-1]) ? ST_DECIDE : ST_WEIGHT;
						if (!ch_rdata[CHILD_DW-1]) begin
							fail_q <= 1'b1;
						end
					end
				end
				ST_WEIGHT: begin
					if (capturing) begin
						wgt_q[cap_idx] <= nd_rdata[NODE_W +: WEIGHT_W];
					end
					step_q <= issuing ? step_q + 1'b1 : '0;
					if (!issuing) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					step_q <= '0;
					if (!fail_q && weights_ok) begin
						for (int j = 0; j < TRACKS; j++) begin
							track_q[j] <= nxt_q[j];
						end
						state_q <= ST_DEPTH;
					end else if (track_q[0] == '0) begin
						state_q <= ST_DEPTH;
					end else if (attempt_q == ATT_W'(MAX_LEN)) begin
						// failure chain too long: back to root
						for (int j = 0; j < TRACKS; j++) begin
							track_q[j] <= '0;
						end
						state_q <= ST_DEPTH;
					end else begin
						state_q <= ST_FAIL;
					end
				end
				ST_FAIL: begin
					if (capturing) begin
						track_q[cap_idx] <= nd_rdata[NODE_W-1:0];
					end
					step_q <= issuing ? step_q + 1'b1 : '0;
					if (!issuing) begin
						attempt_q <= attempt_q + 1'b1;
						fail_q    <= 1'b0;
						state_q   <= ST_CHILD;
					end
				end
				ST_DEPTH: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (load_rsp) begin
						rsp_valid_q <= 1'b1;
						count_q     <= count_q + 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			if (nd_rdata[ENTRY_W-1 -: DEPTH_W] == plen_q) begin
				rsp_q.match_found    <= 1'b1;
				rsp_q.match_position <= count_q - 32'(plen_q) + 32'd1;
			end else begin
				rsp_q.match_found    <= 1'b0;
				rsp_q.match_position <= '0;
			end
		end
	end

	a_attempt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		attempt_q <= ATT_W'(MAX_LEN))
		else $error("attempt count past limit");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> req_stall)
		else $error("item taken during clearing pass");

	a_rsp_from_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q) == ST_RES)
		else $error("result raised outside result phase");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(load_rsp && !(state_q == ST_IDLE)) |=> count_q == $past(count_q) + 32'd1)
		else $error("column count not advanced");
endmodule

[hdl/mtpm_child_mem.sv]
// Child edge table: one write port, one registered read port.
module mtpm_child_mem (
	input  logic                           clk,
	input  logic                           we,
	input  logic [mtpm_pkg::CHILD_AW-1:0]  waddr,
	input  logic [mtpm_pkg::CHILD_DW-1:0]  wdata,
	input  logic [mtpm_pkg::CHILD_AW-1:0]  raddr,
	output logic [mtpm_pkg::CHILD_DW-1:0]  rdata
);
	import mtpm_pkg::*;

	logic [CHILD_DW-1:0] mem [NODES*ALPHABET];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/mtpm_node_mem.sv]
// Node table: depth, weight and failure link per node, registered read.
module mtpm_node_mem (
	input  logic                          clk,
	input  logic                          we,
	input  logic [mtpm_pkg::NODE_W-1:0]   waddr,
	input  logic [mtpm_pkg::ENTRY_W-1:0]  wdata,
	input  logic [mtpm_pkg::NODE_W-1:0]   raddr,
	output logic [mtpm_pkg::ENTRY_W-1:0]  rdata
);
	import mtpm_pkg::*;

	logic [ENTRY_W-1:0] mem [NODES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
